// ===== src/pfc_pkg.sv =====
// pfc_pkg: format codes and channel scaling helpers for the pixel format converter.
// No dependencies; used by pixel_format_converter.
package pfc_pkg;

  typedef enum logic [2:0] {
    FMT_ARGB8888 = 3'd0,
    FMT_RGB888   = 3'd1,
    FMT_XRGB8888 = 3'd2,
    FMT_RGB565   = 3'd3,
    FMT_XRGB1555 = 3'd4,
    FMT_ARGB1555 = 3'd5,
    FMT_ARGB4444 = 3'd6,
    FMT_BAD      = 3'd7
  } fmt_e;

  localparam logic [2:0] BYTES_NONE = 3'd0;
  localparam logic [2:0] BYTES_2    = 3'd2;
  localparam logic [2:0] BYTES_3    = 3'd3;
  localparam logic [2:0] BYTES_4    = 3'd4;

  // floor(v*255/31) = (v * 255 * ceil(2^18/31)) >> 18, exact for v <= 31
  localparam int unsigned Widen31Mul = 255 * 8457;
  // floor(v*255/63) = (v * 255 * ceil(2^20/63)) >> 20, exact for v <= 63
  localparam int unsigned Widen63Mul = 255 * 16645;

  function automatic logic [7:0] widen5(logic [4:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'(Widen31Mul);
    return p[25:18];
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'(Widen63Mul);
    return p[27:20];
  endfunction

  // 255/15 is exactly 17
  function automatic logic [7:0] widen4(logic [3:0] v);
    return {v, v};
  endfunction

  // floor(c*m/255); x/255 == (x + 1 + (x >> 8)) >> 8 for x below 65535
  function automatic logic [5:0] narrow(logic [7:0] c, logic [5:0] m);
    logic [13:0] x;
    logic [14:0] t;
    x = 14'(c) * 14'(m);
    t = {1'b0, x} + 15'd1 + 15'(x[13:8]);
    return t[13:8];
  endfunction

endpackage

// ===== src/pixel_format_converter.sv =====
// pixel_format_converter: streaming pixel decode/encode between ARGB8888 and surface formats.
// Depends on pfc_pkg for format codes and channel scaling functions.

// One pixel per request, one result per request, sustained at one pixel per clock
// while m_axis_tready_i is high. A request passes an input register, then the
// conversion logic (one constant multiply and an add per channel) into the result
// register, which drives m_axis_tvalid_o. Backpressure on the master side
// stalls both stages; the input stage still takes a request while the result
// register is full and about to drain. Unsupported format codes give a zero
// pixel, zero byte count and the bad_format flag in tuser.
module pixel_format_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] pixel_in
  input  logic [3:0]  s_axis_tuser_i,   // [0] mode, [3:1] format
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] pixel_out, [34:32] byte_count, [39:35] zero
  output logic [0:0]  m_axis_tuser_o    // [0] bad_format
);

  logic        in_valid_q;
  logic        in_mode_q;
  logic [2:0]  in_fmt_q;
  logic [31:0] in_px_q;

  logic        out_valid_q;
  logic [31:0] out_px_q, out_px_d;
  logic [2:0]  out_bytes_q, out_bytes_d;
  logic        out_bad_q, out_bad_d;

  logic out_adv;
  logic in_take;

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || out_adv;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (out_adv) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q <= s_axis_tuser_i[0];
      in_fmt_q  <= s_axis_tuser_i[3:1];
      in_px_q   <= s_axis_tdata_i;
    end
    if (out_adv && in_valid_q) begin
      out_px_q    <= out_px_d;
      out_bytes_q <= out_bytes_d;
      out_bad_q   <= out_bad_d;
    end
  end

  logic [7:0] ch_r, ch_g, ch_b;
  assign ch_r = in_px_q[23:16];
  assign ch_g = in_px_q[15:8];
  assign ch_b = in_px_q[7:0];

  always_comb begin
    out_px_d    = '0;
    out_bytes_d = pfc_pkg::BYTES_NONE;
    out_bad_d   = 1'b0;
    case (in_fmt_q) inside
      pfc_pkg::FMT_ARGB8888: begin
        out_px_d    = in_px_q;
        out_bytes_d = pfc_pkg::BYTES_4;
      end
      pfc_pkg::FMT_RGB888: begin
        out_px_d    = {(in_mode_q ? 8'h00 : 8'hff), in_px_q[23:0]};
        out_bytes_d = pfc_pkg::BYTES_3;
      end
      pfc_pkg::FMT_XRGB8888: begin
        out_px_d    = {8'hff, in_px_q[23:0]};
        out_bytes_d = pfc_pkg::BYTES_4;
      end
      pfc_pkg::FMT_RGB565: begin
        if (in_mode_q) begin
          out_px_d = {16'h0000,
                      5'(pfc_pkg::narrow(ch_r, 6'd31)),
                      pfc_pkg::narrow(ch_g, 6'd63),
                      5'(pfc_pkg::narrow(ch_b, 6'd31))};
        end else begin
          out_px_d = {8'hff,
                      pfc_pkg::widen5(in_px_q[15:11]),
                      pfc_pkg::widen6(in_px_q[10:5]),
                      pfc_pkg::widen5(in_px_q[4:0])};
        end
        out_bytes_d = pfc_pkg::BYTES_2;
      end
      pfc_pkg::FMT_XRGB1555, pfc_pkg::FMT_ARGB1555: begin
        if (in_mode_q) begin
          out_px_d = {17'h00000,
                      5'(pfc_pkg::narrow(ch_r, 6'd31)),
                      5'(pfc_pkg::narrow(ch_g, 6'd31)),
                      5'(pfc_pkg::narrow(ch_b, 6'd31))};
        end else begin
          out_px_d = {8'hff,
                      pfc_pkg::widen5(in_px_q[14:10]),
                      pfc_pkg::widen5(in_px_q[9:5]),
                      pfc_pkg::widen5(in_px_q[4:0])};
        end
        out_bytes_d = pfc_pkg::BYTES_2;
      end
      pfc_pkg::FMT_ARGB4444: begin
        if (in_mode_q) begin
          out_px_d = {20'h00000,
                      4'(pfc_pkg::narrow(ch_r, 6'd15)),
                      4'(pfc_pkg::narrow(ch_g, 6'd15)),
                      4'(pfc_pkg::narrow(ch_b, 6'd15))};
        end else begin
          out_px_d = {8'hff,
                      pfc_pkg::widen4(in_px_q[11:8]),
                      pfc_pkg::widen4(in_px_q[7:4]),
                      pfc_pkg::widen4(in_px_q[3:0])};
        end
        out_bytes_d = pfc_pkg::BYTES_2;
      end
      default: begin
        out_bad_d = 1'b1;
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_bytes_q, out_px_q};
  assign m_axis_tuser_o  = out_bad_q;

  // unsupported format returns an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bad_q |-> out_px_q == 32'h0 && out_bytes_q == pfc_pkg::BYTES_NONE)
    else $error("bad format result not zero");

  // a supported format always reports 2, 3 or 4 bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_bad_q |->
      out_bytes_q == pfc_pkg::BYTES_2 || out_bytes_q == pfc_pkg::BYTES_3 ||
      out_bytes_q == pfc_pkg::BYTES_4)
    else $error("byte count out of range");

  // an accepted request lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted request lost");

  // a full input stage drains into the result register when it advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_adv |=> out_valid_q)
    else $error("result register missed a request");

endmodule
